[hdl/checksummed_line_frame_decoder_defines.svh]
// assertion macros shared by the checker
`ifndef CHECKSUMMED_LINE_FRAME_DECODER_DEFINES_SVH
`define CHECKSUMMED_LINE_FRAME_DECODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/cfd_pkg.sv]
package cfd_pkg;

  localparam int MAX_PREFIX_DEF = 8;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CRC_POLY   = 8'h07;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_PREFIX_CHARS    = 2'd0;
  localparam logic [1:0] CFG_PREFIX_LENGTH   = 2'd1;
  localparam logic [1:0] CFG_MAX_PAYLOAD_LEN = 2'd2;

  localparam logic [63:0] PREFIX_CHARS_RST    = 64'd36;
  localparam logic [3:0]  PREFIX_LENGTH_RST   = 4'd1;
  localparam logic [15:0] MAX_PAYLOAD_LEN_RST = 16'd255;

  typedef enum logic [2:0] {
    PH_PREFIX  = 3'd0,
    PH_SEQ     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_HEX1    = 3'd3,
    PH_HEX2    = 3'd4,
    PH_TAIL    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [63:0] prefix_chars;
    logic [3:0]  prefix_length;
    logic [15:0] max_payload_len;
  } cfg_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    logic        frame_ok;
    logic [15:0] sequence_res;
  } res_t;

  // one byte through crc-8, msb first
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] c);
    logic [7:0] r;
    r = crc ^ c;
    for (int b = 0; b < 8; b++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  // bit 4 set for a non-hex character
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = {1'b0, 4'(c - CHAR_ZERO)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

[hdl/cfd_parse.sv]
module cfd_parse #(
  parameter int MAX_PREFIX = cfd_pkg::MAX_PREFIX_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic [7:0]    char_byte,
  input  logic          line_end,
  input  cfd_pkg::cfg_t cfg,
  output cfd_pkg::res_t res
);
  import cfd_pkg::*;

  localparam int PW = $clog2(MAX_PREFIX + 1);

  phase_t      phase_r, phase_nxt, work_phase;
  logic [PW-1:0] pos_r, pos_nxt, plen, pos_inc;
  logic [15:0] seq_r, seq_nxt;
  logic        digit_r, digit_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  rcrc_r, rcrc_nxt;
  logic [16:0] cnt_r, cnt_nxt, cnt_inc;
  logic        failed_r, failed_nxt;
  logic        first_r, first_nxt;
  logic [2:0]  want_idx;
  logic [7:0]  want;
  logic [19:0] acc;
  logic [4:0]  hex;
  logic        ok;

  assign plen     = (cfg.prefix_length > MAX_PREFIX) ? PW'(MAX_PREFIX) : PW'(cfg.prefix_length);
  assign pos_inc  = pos_r + 1'b1;
  assign want_idx = 3'(pos_r);
  assign want     = cfg.prefix_chars[8*want_idx +: 8];
  assign acc      = ({4'b0, seq_r} << 3) + ({4'b0, seq_r} << 1) + 20'(8'(char_byte - CHAR_ZERO));
  assign cnt_inc  = cnt_r + 17'd1;
  assign hex      = hex_value(char_byte);
  assign ok       = !failed_r && (phase_r == PH_TAIL) && (crc_r == rcrc_r);

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    seq_nxt    = seq_r;
    digit_nxt  = digit_r;
    crc_nxt    = crc_r;
    rcrc_nxt   = rcrc_r;
    cnt_nxt    = cnt_r;
    failed_nxt = failed_r;
    first_nxt  = first_r;
    work_phase = phase_r;
    res        = '0;
    if (line_end || char_byte == 8'd0) begin
      res.frame_done   = 1'b1;
      res.frame_ok     = ok;
      res.sequence_res = ok ? seq_r : 16'd0;
      phase_nxt  = PH_PREFIX;
      pos_nxt    = '0;
      seq_nxt    = '0;
      digit_nxt  = 1'b0;
      crc_nxt    = '0;
      rcrc_nxt   = '0;
      cnt_nxt    = '0;
      failed_nxt = 1'b0;
      first_nxt  = 1'b0;
    end else begin
      // crc skips the first character and stops at the star
      if (first_r && (phase_r == PH_PREFIX || phase_r == PH_SEQ || phase_r == PH_PAYLOAD)
          && char_byte != CHAR_STAR) begin
        crc_nxt = crc_step(crc_r, char_byte);
      end
      first_nxt = 1'b1;
      if (!failed_r) begin
        if (phase_r == PH_PREFIX) begin
          if (pos_r < plen) begin
            if (char_byte != want) begin
              failed_nxt = 1'b1;
            end else begin
              pos_nxt = pos_inc;
              if (pos_inc >= plen) phase_nxt = PH_SEQ;
            end
          end else begin
            // empty prefix: this character already belongs to the sequence
            phase_nxt  = PH_SEQ;
            work_phase = PH_SEQ;
          end
        end
        unique case (work_phase)
          PH_PREFIX: begin
          end
          PH_SEQ: begin
            if (char_byte >= CHAR_ZERO && char_byte <= CHAR_NINE) begin
              seq_nxt   = acc[15:0];
              digit_nxt = 1'b1;
              if (acc > 20'hFFFF) failed_nxt = 1'b1;
            end else if (char_byte == CHAR_COMMA && digit_r) begin
              phase_nxt = PH_PAYLOAD;
            end else begin
              failed_nxt = 1'b1;
            end
          end
          PH_PAYLOAD: begin
            if (char_byte == CHAR_STAR) begin
              phase_nxt = PH_HEX1;
            end else begin
              cnt_nxt = cnt_inc;
              if (cnt_inc > {1'b0, cfg.max_payload_len}) begin
                failed_nxt = 1'b1;
              end else begin
                res.payload_valid = 1'b1;
                res.payload_byte  = char_byte;
              end
            end
          end
          PH_HEX1, PH_HEX2: begin
            if (hex[4]) begin
              failed_nxt = 1'b1;
            end else begin
              rcrc_nxt  = {rcrc_r[3:0], hex[3:0]};
              phase_nxt = (work_phase == PH_HEX1) ? PH_HEX2 : PH_TAIL;
            end
          end
          default: failed_nxt = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PREFIX;
      pos_r    <= '0;
      seq_r    <= '0;
      digit_r  <= 1'b0;
      crc_r    <= '0;
      rcrc_r   <= '0;
      cnt_r    <= '0;
      failed_r <= 1'b0;
      first_r  <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      seq_r    <= seq_nxt;
      digit_r  <= digit_nxt;
      crc_r    <= crc_nxt;
      rcrc_r   <= rcrc_nxt;
      cnt_r    <= cnt_nxt;
      failed_r <= failed_nxt;
      first_r  <= first_nxt;
    end
  end

endmodule

[hdl/checksummed_line_frame_decoder.sv]
// channel  | direction | handshake           | beat
// in_      | in        | in_valid/in_ready   | one character, or a line end
// out_     | out       | out_valid/out_ready | one result per input beat
// cfg_     | in        | cfg_we              | one register write, no wait
//
// one beat per cycle while out_ready stays high; a beat taken is offered as a result after the
// input register, one pass of parse logic, output register
// the line state advances only when a beat moves into the output register
// rst_n is synchronous; it clears the line state and loads register defaults
// a stalled output holds its beat while the input register keeps one more
module checksummed_line_frame_decoder #(
  parameter int MAX_PREFIX = cfd_pkg::MAX_PREFIX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_line_end,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic        out_frame_done,
  output logic        out_frame_ok,
  output logic [15:0] out_sequence_res,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import cfd_pkg::*;

  // configuration registers
  cfg_t cfg_r;

  // input register
  logic       a_valid_r;
  logic [7:0] a_char_r;
  logic       a_end_r;

  // output register
  logic out_valid_r;
  res_t res_r;
  res_t res;

  logic advance;

  // a held beat moves on whenever the output register is free or drains
  assign advance  = a_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !a_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prefix_chars    <= PREFIX_CHARS_RST;
      cfg_r.prefix_length   <= PREFIX_LENGTH_RST;
      cfg_r.max_payload_len <= MAX_PAYLOAD_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PREFIX_CHARS:    cfg_r.prefix_chars    <= cfg_data;
        CFG_PREFIX_LENGTH:   cfg_r.prefix_length   <= cfg_data[3:0];
        CFG_MAX_PAYLOAD_LEN: cfg_r.max_payload_len <= cfg_data[15:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_char_r <= in_char_byte;
      a_end_r  <= in_line_end;
    end
  end

  // per-character parse, crc and line state
  cfd_parse #(
    .MAX_PREFIX(MAX_PREFIX)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (advance),
    .char_byte(a_char_r),
    .line_end (a_end_r),
    .cfg      (cfg_r),
    .res      (res)
  );

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_valid = res_r.payload_valid;
  assign out_payload_byte  = res_r.payload_byte;
  assign out_frame_done    = res_r.frame_done;
  assign out_frame_ok      = res_r.frame_ok;
  assign out_sequence_res  = res_r.sequence_res;

endmodule

[hdl/cfd_checker.sv]
`include "checksummed_line_frame_decoder_defines.svh"

module cfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_payload_valid,
  input logic [7:0]  out_payload_byte,
  input logic        out_frame_done,
  input logic        out_frame_ok,
  input logic [15:0] out_sequence_res
);

  `CFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload_byte) && $stable(out_sequence_res), "stalled result beat changed")
  `CFD_ASSERT_NOW(a_ok_needs_done, out_valid && out_frame_ok, out_frame_done, "frame_ok without frame_done")
  `CFD_ASSERT_NOW(a_payload_not_end, out_valid && out_payload_valid, !out_frame_done, "payload byte on a line end beat")
  `CFD_ASSERT_NOW(a_seq_zero_on_fail, out_valid && !out_frame_ok, out_sequence_res == 16'd0, "sequence shown on a failed or open line")

endmodule

bind checksummed_line_frame_decoder cfd_checker u_cfd_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import cfd_pkg::*;

  // no beat on either side for this many cycles means the block is stuck
  localparam int WATCHDOG_LIMIT = 2000;
  // idle cycles after the last result before a register write or the end
  localparam int SETTLE_CYCLES = 6;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  // beyond the register list, a write here must change nothing
  localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

  typedef enum int {HEX_UPPER, HEX_LOWER, HEX_MIXED} hex_case_t;
  typedef enum int {SPOIL_CRC, SPOIL_TRAIL, SPOIL_CUT, SPOIL_SWAP, SPOIL_INSERT} spoil_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_byte = 8'h00;
  logic        in_line_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_payload_valid;
  logic [7:0]  out_payload_byte;
  logic        out_frame_done;
  logic        out_frame_ok;
  logic [15:0] out_sequence_res;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [63:0] cfg_data = 64'd0;

  checksummed_line_frame_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_byte     (in_char_byte),
    .in_line_end      (in_line_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_valid(out_payload_valid),
    .out_payload_byte (out_payload_byte),
    .out_frame_done   (out_frame_done),
    .out_frame_ok     (out_frame_ok),
    .out_sequence_res (out_sequence_res),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // decoder prediction: own copy of the registers and of the line state
  // ---------------------------------------------------------------------------
  cfg_t       shadow_cfg;
  phase_t     line_phase;
  int         prefix_pos;
  int         seq_acc;
  bit         digit_seen;
  logic [7:0] crc_run;
  logic [7:0] crc_rx;
  int         pay_count;
  bit         line_bad;
  bit         seen_first;

  res_t pending_results[$];   // predicted results, oldest first
  logic [7:0] line_chars[$];  // characters of the line being built
  int   chars_sent = 0;
  int   mismatch_count = 0;
  bit   steady = 1'b0;        // no new idling starts on either side while set

  function automatic void clear_line_state();
    line_phase = PH_PREFIX;
    prefix_pos = 0;
    seq_acc = 0;
    digit_seen = 1'b0;
    crc_run = 8'h00;
    crc_rx = 8'h00;
    pay_count = 0;
    line_bad = 1'b0;
    seen_first = 1'b0;
  endfunction

  // crc-8 poly 0x07, fed one bit at a time msb first
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] c);
    logic [7:0] acc;
    logic fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = acc[7] ^ c[i];
      acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return acc;
  endfunction

  // 16 marks a character that is no hex digit
  function automatic int hex_digit_value(input logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_A + 8'd5) return int'(c - CHAR_UPPER_A) + 10;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_A + 8'd5) return int'(c - CHAR_LOWER_A) + 10;
    return 16;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return CHAR_ZERO + 8'(n);
    return (lower ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(n) - 8'd10;
  endfunction

  // one input beat through the line parser; returns the result it causes
  function automatic res_t decode_beat(input logic [7:0] c, input logic lend);
    res_t r;
    int plen;
    int hexv;
    r = '0;
    plen = (shadow_cfg.prefix_length > MAX_PREFIX_DEF) ? MAX_PREFIX_DEF
                                                      : int'(shadow_cfg.prefix_length);
    // line end, flagged or by a zero character
    if (lend || c == 8'h00) begin
      r.frame_done = 1'b1;
      if (!line_bad && line_phase == PH_TAIL && crc_run == crc_rx) begin
        r.frame_ok = 1'b1;
        r.sequence_res = seq_acc[15:0];
      end
      clear_line_state();
      return r;
    end
    // checksum runs from the second character up to the star, even on a bad line
    if (seen_first && line_phase <= PH_PAYLOAD && c != CHAR_STAR)
      crc_run = crc8_feed(crc_run, c);
    seen_first = 1'b1;
    if (line_bad) return r;

    if (line_phase == PH_PREFIX) begin
      if (prefix_pos < plen) begin
        if (c != shadow_cfg.prefix_chars[8*prefix_pos +: 8]) begin
          line_bad = 1'b1;
        end else begin
          prefix_pos++;
          if (prefix_pos >= plen) line_phase = PH_SEQ;
        end
        return r;
      end
      // empty prefix: this character already belongs to the sequence
      line_phase = PH_SEQ;
    end

    case (line_phase)
      PH_SEQ: begin
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
          seq_acc = seq_acc * 10 + int'(c - CHAR_ZERO);
          digit_seen = 1'b1;
          if (seq_acc > 65535) line_bad = 1'b1;
        end else if (c == CHAR_COMMA && digit_seen) begin
          line_phase = PH_PAYLOAD;
        end else begin
          line_bad = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        if (c == CHAR_STAR) begin
          line_phase = PH_HEX1;
        end else begin
          pay_count++;
          if (pay_count > int'(shadow_cfg.max_payload_len)) begin
            line_bad = 1'b1;
          end else begin
            r.payload_valid = 1'b1;
            r.payload_byte = c;
          end
        end
      end
      PH_HEX1, PH_HEX2: begin
        hexv = hex_digit_value(c);
        if (hexv > 15) begin
          line_bad = 1'b1;
        end else begin
          crc_rx = {crc_rx[3:0], 4'(hexv)};
          line_phase = (line_phase == PH_HEX1) ? PH_HEX2 : PH_TAIL;
        end
      end
      default: line_bad = 1'b1;  // anything after the two hex digits
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // idling on both sides
  // ---------------------------------------------------------------------------
  function automatic int sender_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic int receiver_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  int stall_left = 0;

  // out_ready drops for random stretches, mostly short
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      stall_left <= receiver_stall() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result checking, sampled mid-cycle so the edge order never matters
  // ---------------------------------------------------------------------------
  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  int quiet_cycles = 0;

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(negedge clk) begin : check_results
    res_t want;
    in_fire = rst_n && in_valid && (in_ready === 1'b1);
    out_fire = rst_n && (out_valid === 1'b1) && out_ready;
    if (out_fire) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, got done=%b ok=%b pv=%b",
                 $time, out_frame_done, out_frame_ok, out_payload_valid);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("payload_valid", 16'(want.payload_valid), 16'(out_payload_valid));
        check_field("payload_byte", 16'(want.payload_byte), 16'(out_payload_byte));
        check_field("frame_done", 16'(want.frame_done), 16'(out_frame_done));
        check_field("frame_ok", 16'(want.frame_ok), 16'(out_frame_ok));
        check_field("sequence_res", want.sequence_res, out_sequence_res);
      end
    end
  end

  // stuck detection: counts cycles in which no beat moves on either side
  always @(posedge clk) begin
    if (in_fire || out_fire) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one character beat; valid stays up after the beat unless a gap follows
  task automatic send_beat(input logic [7:0] ch, input logic lend);
    int gap;
    bit taken;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= ch;
    in_line_end <= lend;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (in_ready === 1'b1);
      @(posedge clk);
    end
    pending_results.push_back(decode_beat(ch, lend));
    chars_sent++;
  endtask

  // sender goes quiet until every predicted result is back, then settles
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PREFIX_CHARS:    shadow_cfg.prefix_chars = val;
      CFG_PREFIX_LENGTH:   shadow_cfg.prefix_length = val[3:0];
      CFG_MAX_PAYLOAD_LEN: shadow_cfg.max_payload_len = val[15:0];
      default: ;
    endcase
  endtask

  // well-formed line for the current registers, into line_chars
  // fill < 0 gives random payload characters
  task automatic compose_frame(input longint seq_val, input int zeros, input int pay_len,
                               input int fill, input hex_case_t hcase);
    string digits;
    int plen;
    logic [7:0] c;
    logic [7:0] crc;
    line_chars.delete();
    plen = (shadow_cfg.prefix_length > MAX_PREFIX_DEF) ? MAX_PREFIX_DEF
                                                      : int'(shadow_cfg.prefix_length);
    for (int k = 0; k < plen; k++) line_chars.push_back(shadow_cfg.prefix_chars[8*k +: 8]);
    repeat (zeros) line_chars.push_back(CHAR_ZERO);
    digits = $sformatf("%0d", seq_val);
    for (int k = 0; k < digits.len(); k++) line_chars.push_back(digits[k]);
    line_chars.push_back(CHAR_COMMA);
    repeat (pay_len) begin
      if (fill >= 0) begin
        c = 8'(fill);
      end else begin
        do c = 8'($urandom_range(1, 255)); while (c == CHAR_STAR);
      end
      line_chars.push_back(c);
    end
    // first character of the line stays out of the checksum
    crc = 8'h00;
    for (int k = 1; k < line_chars.size(); k++)
      if (line_chars[k] != CHAR_STAR) crc = crc8_feed(crc, line_chars[k]);
    line_chars.push_back(CHAR_STAR);
    line_chars.push_back(hex_char(crc[7:4], hcase == HEX_LOWER ||
                                  (hcase == HEX_MIXED && $urandom_range(0, 1) == 1)));
    line_chars.push_back(hex_char(crc[3:0], hcase == HEX_LOWER ||
                                  (hcase == HEX_MIXED && $urandom_range(0, 1) == 1)));
  endtask

  // one random fault: bad checksum or hex, trailing junk, early end, replaced or stray byte
  task automatic spoil_line();
    spoil_t kind;
    int pos;
    int n;
    kind = spoil_t'($urandom_range(0, 4));
    case (kind)
      SPOIL_CRC: begin
        pos = line_chars.size() - 1 - $urandom_range(0, 1);
        line_chars[pos] = line_chars[pos] ^ 8'h01;
      end
      SPOIL_TRAIL: repeat ($urandom_range(1, 3)) line_chars.push_back(8'($urandom_range(1, 255)));
      SPOIL_CUT: begin
        n = $urandom_range(0, line_chars.size() - 1);
        while (line_chars.size() > n) void'(line_chars.pop_back());
      end
      SPOIL_SWAP: begin
        pos = $urandom_range(0, line_chars.size() - 1);
        line_chars[pos] = 8'($urandom_range(0, 255));
      end
      default: line_chars.insert($urandom_range(0, line_chars.size()),
                                 8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic send_chars(input int first, input int last);
    for (int k = first; k < last; k++) send_beat(line_chars[k], 1'b0);
  endtask

  // end of line either by the flag (character ignored) or by a zero byte
  task automatic end_line();
    if ($urandom_range(0, 1) == 1) send_beat(8'($urandom_range(0, 255)), 1'b1);
    else send_beat(8'h00, 1'b0);
  endtask

  task automatic random_line();
    int maxp;
    int pay_len;
    int zeros;
    longint seq_val;
    line_chars.delete();
    if ($urandom_range(0, 99) < 8) begin
      // noise, zero bytes included
      repeat ($urandom_range(0, 12)) line_chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 9))
        0:       seq_val = 65536 + $urandom_range(0, 934463);
        1:       seq_val = 65535;
        2:       seq_val = 0;
        3, 4:    seq_val = $urandom_range(0, 65535);
        default: seq_val = $urandom_range(0, 999);
      endcase
      zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
      maxp = (shadow_cfg.max_payload_len < 16'd12) ? int'(shadow_cfg.max_payload_len) : 12;
      // short limits get a payload one or two over now and then
      if (maxp < 12 && $urandom_range(0, 5) == 0) pay_len = maxp + $urandom_range(1, 2);
      else pay_len = $urandom_range(0, maxp);
      compose_frame(seq_val, zeros, pay_len, -1, HEX_MIXED);
      if ($urandom_range(0, 99) < 20) spoil_line();
    end
    send_chars(0, line_chars.size());
    end_line();
  endtask

  task automatic run_random_lines(input int n_items);
    int start;
    start = chars_sent;
    while (chars_sent - start < n_items) random_line();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset registers: largest sequence with byte 0xff, smallest sequence with
  // empty payload, and a sequence that overflows and then ends early
  task automatic test_directed_lines();
    compose_frame(65535, 0, 1, 255, HEX_UPPER);
    send_chars(0, line_chars.size());
    send_beat(8'hA5, 1'b1);
    compose_frame(0, 0, 0, -1, HEX_LOWER);
    send_chars(0, line_chars.size());
    send_beat(8'h00, 1'b0);
    compose_frame(65536, 0, 0, -1, HEX_UPPER);
    while (line_chars.size() > 6) void'(line_chars.pop_back());
    send_chars(0, line_chars.size());
    send_beat(8'h00, 1'b1);
  endtask

  task automatic test_default_random();
    run_random_lines(120);
    // a stretch in which no new idling starts
    steady = 1'b1;
    run_random_lines(40);
    steady = 1'b0;
    // sender holds off until the result side has emptied
    wait_drain();
    run_random_lines(40);
  endtask

  // empty prefix: the first digit is parsed but stays out of the checksum
  task automatic test_no_prefix();
    write_reg(CFG_PREFIX_CHARS, 64'h0);
    write_reg(CFG_PREFIX_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0);
    compose_frame(7, 0, 2, -1, HEX_MIXED);
    send_chars(0, line_chars.size());
    end_line();
    run_random_lines(50);
  endtask

  task automatic test_long_prefix();
    write_reg(CFG_PREFIX_CHARS, 64'h4645_4443_4241_5650);
    write_reg(CFG_PREFIX_LENGTH, 64'd8);
    run_random_lines(70);
  endtask

  // length above the prefix store saturates at eight characters
  task automatic test_prefix_saturation();
    write_reg(CFG_PREFIX_CHARS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_PREFIX_LENGTH, 64'd15);
    run_random_lines(50);
  endtask

  task automatic test_payload_limits();
    write_reg(CFG_PREFIX_CHARS, 64'(CHAR_DOLLAR));
    write_reg(CFG_PREFIX_LENGTH, 64'd1);
    // zero limit: the one payload character is dropped and the line fails
    write_reg(CFG_MAX_PAYLOAD_LEN, 64'd0);
    compose_frame(5, 0, 1, -1, HEX_UPPER);
    send_chars(0, line_chars.size());
    end_line();
    run_random_lines(40);
    write_reg(CFG_MAX_PAYLOAD_LEN, 64'd3);
    run_random_lines(50);
    write_reg(CFG_MAX_PAYLOAD_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
    run_random_lines(50);
  endtask

  // limit tightened while a line is half through: later characters see it
  task automatic test_midline_write();
    write_reg(CFG_MAX_PAYLOAD_LEN, 64'd5);
    compose_frame(42, 0, 4, -1, HEX_MIXED);
    send_chars(0, 5);
    write_reg(CFG_MAX_PAYLOAD_LEN, 64'd2);
    write_reg(CFG_UNUSED_INDEX, {$urandom, $urandom});
    send_chars(5, line_chars.size());
    end_line();
    run_random_lines(40);
  endtask

  initial begin
    // times in reports are printed in whole nanoseconds
    $timeformat(-9, 0, "", 0);
    shadow_cfg.prefix_chars = PREFIX_CHARS_RST;
    shadow_cfg.prefix_length = PREFIX_LENGTH_RST;
    shadow_cfg.max_payload_len = MAX_PAYLOAD_LEN_RST;
    clear_line_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_lines();
    test_default_random();
    test_no_prefix();
    test_long_prefix();
    test_prefix_saturation();
    test_payload_limits();
    test_midline_write();

    wait_drain();
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
